// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the looper.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("looper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("looper assertion failed");

`endif

// ===== sv/slp_pkg.sv =====
// Shared types and fixed constants of the stereo looper.
// No dependencies; used by the interfaces, the top level and the checker.
package slp_pkg;

	typedef enum logic [3:0] {
		ACT_RECORD     = 4'd0,
		ACT_TICK       = 4'd1,
		ACT_REC_START  = 4'd2,
		ACT_REC_STOP   = 4'd3,
		ACT_PLAY_START = 4'd4,
		ACT_PLAY_STOP  = 4'd5,
		ACT_SET_START  = 4'd6,
		ACT_SET_END    = 4'd7,
		ACT_CLEAR      = 4'd8
	} action_t;

	localparam int ACT_W   = 4;
	localparam int FRAC_W  = 17;
	localparam int Q16     = 16;
	localparam int SPEED_W = 21;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX   = 21'sd524288;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN   = -21'sd524288;
	localparam logic signed [SPEED_W-1:0] SPEED_RESET = 21'sd65536;

	// Register index, taken from address bit 2.
	localparam logic REG_SPEED = 1'b0;

endpackage

// ===== sv/slp_in_if.sv =====
// Input channel of the looper: one action beat with its samples and fraction.
// Depends on slp_pkg for field widths.
interface slp_in_if #(parameter int SAMPLE_BITS = 24);
	logic                              valid;
	logic                              ready;
	logic [slp_pkg::ACT_W-1:0]         action;
	logic signed [SAMPLE_BITS-1:0]     left_in;
	logic signed [SAMPLE_BITS-1:0]     right_in;
	logic [slp_pkg::FRAC_W-1:0]        loop_fraction;

	modport source(output valid, action, left_in, right_in, loop_fraction, input ready);
	modport sink(input valid, action, left_in, right_in, loop_fraction, output ready);
endinterface

// ===== sv/slp_out_if.sv =====
// Result channel of the looper: playback samples, position and status flags.
// Depends on slp_pkg for field widths.
interface slp_out_if #(parameter int SAMPLE_BITS = 24);
	logic                              valid;
	logic                              ready;
	logic signed [SAMPLE_BITS-1:0]     left_out;
	logic signed [SAMPLE_BITS-1:0]     right_out;
	logic [slp_pkg::FRAC_W-1:0]        position;
	logic                              is_playing;
	logic                              is_recording;

	modport source(output valid, left_out, right_out, position, is_playing, is_recording,
		input ready);
	modport sink(input valid, left_out, right_out, position, is_playing, is_recording,
		output ready);
endinterface

// ===== sv/slp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2097152
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/slp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by loop wrap and position.
// No dependencies.
module slp_div #(
	parameter int W = 59
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			cnt_q  <= CW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== sv/slp_mul.sv =====
// Registered signed multiplier used for interpolation and loop-bound scaling.
// No dependencies.
module slp_mul #(
	parameter int AW = 26,
	parameter int BW = 18
) (
	input  logic                      clk,
	input  logic signed [AW-1:0]      a,
	input  logic signed [BW-1:0]      b,
	output logic signed [AW+BW-1:0]   p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule

// ===== sv/stereo_loop_sampler.sv =====
// Stereo looper top level: sequencer, state registers, sample stores and APB port.
// Depends on slp_pkg, slp_in_if, slp_out_if, slp_ram, slp_div and slp_mul.
//
// Usage: each beat on in_ch carries one action (record, play tick, start or stop
// recording, start or stop playback, set loop start or end, clear). Every accepted
// beat yields exactly one beat on out_ch with the playback samples, the position
// as a Q1.16 fraction of the recorded length and the two status flags.
// The speed register is written through the APB port at address 0 and is clamped
// to plus or minus 8.0; write it only while the block is idle.
// A simple action goes from S_IDLE through S_POS and S_OUT to the result beat.
// When a take exists and the phase is positive, S_PWAIT waits for the position
// division, W = $clog2(STORE_DEPTH+1) + FRAC_BITS + 21 bits wide (59 at the defaults).
// A play tick adds S_T0 to S_T5 for the two store reads and the two interpolation
// multiplies, and S_WPOS or S_WNEG for a second division when the phase wraps.
// The sequencer and its shared divider handle one item at a time.
// in_ch.ready is high only while the sequencer is idle. A finished result sits in
// the output register; the next item is still accepted, and its result waits in
// the sequencer until out_ch takes the previous one.
// Reset clears all flags, pointers and the phase, sets the loop end to the store
// depth and the speed to 1.0. The sample stores are not cleared; an entry is only
// read after it has been recorded.
module stereo_loop_sampler #(
	parameter int STORE_DEPTH = 2097152,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	slp_in_if.sink                        in_ch,
	slp_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slp_pkg::PADDR_W-1:0]   paddr,
	input  logic [slp_pkg::PDATA_W-1:0]   pwdata,
	output logic [slp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	// Length counters hold the depth itself; store addresses one bit less.
	localparam int AW  = $clog2(STORE_DEPTH + 1);
	localparam int IW  = $clog2(STORE_DEPTH);
	// Phase: sample index plus fraction, with headroom for one speed step.
	localparam int PW  = AW + FRAC_BITS + 5;
	// Divider width: phase shifted up by the Q1.16 position scale.
	localparam int ND  = PW + slp_pkg::Q16;
	localparam int SB1 = SAMPLE_BITS + 1;
	localparam int MA  = (SB1 > AW + 1) ? SB1 : AW + 1;
	localparam int MB  = (FRAC_BITS + 1 > slp_pkg::FRAC_W + 1) ? FRAC_BITS + 1
		: slp_pkg::FRAC_W + 1;
	localparam int IPW = SAMPLE_BITS + FRAC_BITS + 3;
	localparam int UP  = (FRAC_BITS >= slp_pkg::Q16) ? FRAC_BITS - slp_pkg::Q16 : 0;
	localparam int DN  = (FRAC_BITS < slp_pkg::Q16) ? slp_pkg::Q16 - FRAC_BITS : 0;
	localparam int SPX = slp_pkg::SPEED_W + 8;

	localparam logic signed [PW-1:0]  PH_ONE = PW'(1);
	localparam logic signed [IPW-1:0] HALF   = IPW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [IPW-1:0] SMAX   =
		{{(IPW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [IPW-1:0] SMIN   = ~SMAX;
	localparam logic [AW-1:0]         DEPTH_LEN = AW'(STORE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_WPOS, S_WNEG,
		S_F0, S_F1, S_POS, S_PWAIT, S_OUT
	} state_t;

	state_t                              state_q;
	slp_pkg::action_t                    act_q;
	logic [slp_pkg::FRAC_W-1:0]          lf_q;
	logic [AW-1:0]                       wp_q;
	logic [AW-1:0]                       taken_q;
	logic [AW-1:0]                       first_q;
	logic [AW-1:0]                       last_q;
	logic signed [PW-1:0]                phase_q;
	logic                                rec_q;
	logic                                play_q;
	logic signed [slp_pkg::SPEED_W-1:0]  speed_q;
	logic signed [SAMPLE_BITS-1:0]       al_q;
	logic signed [SAMPLE_BITS-1:0]       ar_q;
	logic signed [SB1-1:0]               dr_q;
	logic signed [SAMPLE_BITS-1:0]       lo_q;
	logic signed [SAMPLE_BITS-1:0]       ro_q;
	logic [slp_pkg::FRAC_W-1:0]          pos_q;
	logic                                out_valid_q;
	logic signed [SAMPLE_BITS-1:0]       out_l_q;
	logic signed [SAMPLE_BITS-1:0]       out_r_q;
	logic [slp_pkg::FRAC_W-1:0]          out_pos_q;
	logic                                out_play_q;
	logic                                out_rec_q;

	logic                                accept;
	slp_pkg::action_t                    act_in;
	logic                                store_we;
	logic [IW-1:0]                       raddr;
	logic signed [SAMPLE_BITS-1:0]       rd_l;
	logic signed [SAMPLE_BITS-1:0]       rd_r;

	logic signed [SPX-1:0]               sp_wide;
	logic signed [SPX-1:0]               sp_sh;
	logic signed [PW-1:0]                sp;
	logic signed [PW-1:0]                first_fx;
	logic signed [PW-1:0]                last_fx;
	logic signed [PW-1:0]                unit_fx;
	logic signed [PW-1:0]                taken_ph;
	logic signed [PW-1:0]                tk1;
	logic signed [PW-1:0]                whole;
	logic signed [PW-1:0]                whole1;
	logic signed [PW-1:0]                p0;
	logic signed [PW-1:0]                p1;
	logic [FRAC_BITS-1:0]                frac;
	logic signed [AW:0]                  len;
	logic                                len_ok;
	logic                                wrap_pos;
	logic                                wrap_neg;
	logic                                pos_ok;
	logic signed [SB1-1:0]               diff_l;
	logic signed [SB1-1:0]               diff_r;
	logic [slp_pkg::FRAC_W-1:0]          lf_c;
	logic [AW-1:0]                       fv;
	logic [AW:0]                         end_c;

	logic signed [MA-1:0]                mul_a;
	logic signed [MB-1:0]                mul_b;
	logic signed [MA+MB-1:0]             mul_p;

	logic                                div_start;
	logic [ND-1:0]                       div_dividend;
	logic [ND-1:0]                       div_divisor;
	logic                                div_done;
	logic [ND-1:0]                       div_quo;
	logic [ND-1:0]                       div_rem;
	logic signed [PW-1:0]                rem_ph;

	logic                                cfg_wr;
	logic signed [slp_pkg::SPEED_W-1:0]  cfg_speed;

	// Round half up and saturate one interpolated sample.
	function automatic logic signed [SAMPLE_BITS-1:0] interp_fin(
		input logic signed [SAMPLE_BITS-1:0] a,
		input logic signed [MA+MB-1:0]       p
	);
		logic signed [IPW-1:0] s;
		logic signed [IPW-1:0] r;
		s = (IPW'(a) <<< FRAC_BITS) + IPW'(p) + HALF;
		r = s >>> FRAC_BITS;
		if (r > SMAX) begin
			r = SMAX;
		end else if (r < SMIN) begin
			r = SMIN;
		end
		return SAMPLE_BITS'(r);
	endfunction

	assign accept   = in_ch.valid && in_ch.ready;
	assign act_in   = slp_pkg::action_t'(in_ch.action);
	assign in_ch.ready = (state_q == S_IDLE);
	assign store_we = accept && (act_in == slp_pkg::ACT_RECORD) && rec_q
		&& (wp_q < DEPTH_LEN);

	// Speed in phase units.
	assign sp_wide = SPX'(speed_q);
	assign sp_sh   = (FRAC_BITS >= slp_pkg::Q16) ? (sp_wide <<< UP) : (sp_wide >>> DN);
	assign sp      = PW'(sp_sh);

	assign first_fx = signed'(PW'({first_q, {FRAC_BITS{1'b0}}}));
	assign last_fx  = signed'(PW'({last_q, {FRAC_BITS{1'b0}}}));
	assign len      = signed'({1'b0, last_q}) - signed'({1'b0, first_q});
	assign unit_fx  = signed'(PW'({len[AW-1:0], {FRAC_BITS{1'b0}}}));
	assign taken_ph = signed'(PW'(taken_q));
	assign tk1      = taken_ph - PH_ONE;

	// Read indices: integer part of the phase and its neighbor, clamped.
	assign whole  = phase_q >>> FRAC_BITS;
	assign whole1 = whole + PH_ONE;
	assign frac   = phase_q[FRAC_BITS-1:0];

	always_comb begin
		if (whole[PW-1]) begin
			p0 = '0;
		end else if (whole > tk1) begin
			p0 = tk1;
		end else begin
			p0 = whole;
		end
		if (whole1[PW-1]) begin
			p1 = '0;
		end else if (whole1 > tk1) begin
			p1 = tk1;
		end else begin
			p1 = whole1;
		end
	end

	assign raddr = (state_q == S_T1) ? p1[IW-1:0] : p0[IW-1:0];

	assign len_ok   = !len[AW] && (len != '0);
	assign wrap_pos = len_ok && !speed_q[slp_pkg::SPEED_W-1] && (speed_q != '0)
		&& (phase_q >= last_fx);
	assign wrap_neg = len_ok && speed_q[slp_pkg::SPEED_W-1] && (phase_q < first_fx);
	assign pos_ok   = (taken_q != '0) && !phase_q[PW-1] && (phase_q != '0);

	assign diff_l = SB1'(rd_l) - SB1'(al_q);
	assign diff_r = SB1'(rd_r) - SB1'(ar_q);
	assign lf_c   = (lf_q > slp_pkg::ONE_Q16) ? slp_pkg::ONE_Q16 : lf_q;
	assign fv     = mul_p[slp_pkg::Q16 +: AW];
	assign end_c  = (fv <= first_q) ? ({1'b0, first_q} + (AW + 1)'(1)) : {1'b0, fv};
	assign rem_ph = signed'(PW'(div_rem));

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			S_T2: begin
				mul_a = MA'(diff_l);
				mul_b = MB'(signed'({1'b0, frac}));
			end
			S_T3: begin
				mul_a = MA'(dr_q);
				mul_b = MB'(signed'({1'b0, frac}));
			end
			default: begin
				mul_a = MA'(signed'({1'b0, taken_q}));
				mul_b = MB'(signed'({1'b0, lf_c}));
			end
		endcase
	end

	// Operand selection for the shared divider.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = ND'({phase_q, {slp_pkg::Q16{1'b0}}});
		div_divisor  = ND'({taken_q, {FRAC_BITS{1'b0}}});
		case (state_q)
			S_T5: begin
				if (wrap_pos) begin
					div_start    = 1'b1;
					div_dividend = ND'(phase_q - last_fx);
					div_divisor  = ND'(unit_fx);
				end else if (wrap_neg) begin
					div_start    = 1'b1;
					div_dividend = ND'(first_fx - phase_q);
					div_divisor  = ND'(unit_fx);
				end
			end
			S_POS: begin
				div_start = pos_ok;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign cfg_wr    = psel && penable && pwrite && pready
		&& (paddr[2] == slp_pkg::REG_SPEED);
	assign cfg_speed = signed'(pwdata[slp_pkg::SPEED_W-1:0]);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= slp_pkg::ACT_RECORD;
			lf_q        <= '0;
			wp_q        <= '0;
			taken_q     <= '0;
			first_q     <= '0;
			last_q      <= DEPTH_LEN;
			phase_q     <= '0;
			rec_q       <= 1'b0;
			play_q      <= 1'b0;
			speed_q     <= slp_pkg::SPEED_RESET;
			al_q        <= '0;
			ar_q        <= '0;
			dr_q        <= '0;
			lo_q        <= '0;
			ro_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_pos_q   <= '0;
			out_play_q  <= 1'b0;
			out_rec_q   <= 1'b0;
		end else begin
			// In S_OUT the hand-over below decides the output valid instead.
			if (out_valid_q && out_ch.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (cfg_speed > slp_pkg::SPEED_MAX) begin
					speed_q <= slp_pkg::SPEED_MAX;
				end else if (cfg_speed < slp_pkg::SPEED_MIN) begin
					speed_q <= slp_pkg::SPEED_MIN;
				end else begin
					speed_q <= cfg_speed;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q   <= act_in;
						lf_q    <= in_ch.loop_fraction;
						lo_q    <= '0;
						ro_q    <= '0;
						case (act_in)
							slp_pkg::ACT_RECORD: begin
								if (store_we) begin
									wp_q <= wp_q + AW'(1);
								end
								state_q <= S_POS;
							end
							slp_pkg::ACT_TICK: begin
								if (play_q && (taken_q != '0)) begin
									state_q <= S_T0;
								end else begin
									state_q <= S_POS;
								end
							end
							slp_pkg::ACT_REC_START: begin
								rec_q   <= 1'b1;
								wp_q    <= '0;
								taken_q <= '0;
								state_q <= S_POS;
							end
							slp_pkg::ACT_REC_STOP: begin
								rec_q   <= 1'b0;
								taken_q <= wp_q;
								last_q  <= wp_q;
								state_q <= S_POS;
							end
							slp_pkg::ACT_PLAY_START: begin
								play_q  <= 1'b1;
								phase_q <= first_fx;
								state_q <= S_POS;
							end
							slp_pkg::ACT_PLAY_STOP: begin
								play_q  <= 1'b0;
								state_q <= S_POS;
							end
							slp_pkg::ACT_SET_START, slp_pkg::ACT_SET_END: begin
								state_q <= S_F0;
							end
							slp_pkg::ACT_CLEAR: begin
								wp_q    <= '0;
								taken_q <= '0;
								phase_q <= '0;
								first_q <= '0;
								last_q  <= DEPTH_LEN;
								rec_q   <= 1'b0;
								play_q  <= 1'b0;
								state_q <= S_POS;
							end
							default: begin
								state_q <= S_POS;
							end
						endcase
					end
				end
				// First read address is out; second goes out next.
				S_T0: begin
					state_q <= S_T1;
				end
				S_T1: begin
					al_q    <= rd_l;
					ar_q    <= rd_r;
					state_q <= S_T2;
				end
				S_T2: begin
					dr_q    <= diff_r;
					state_q <= S_T3;
				end
				S_T3: begin
					lo_q    <= interp_fin(al_q, mul_p);
					state_q <= S_T4;
				end
				S_T4: begin
					ro_q    <= interp_fin(ar_q, mul_p);
					phase_q <= phase_q + sp;
					state_q <= S_T5;
				end
				S_T5: begin
					if (!len_ok) begin
						play_q  <= 1'b0;
						state_q <= S_POS;
					end else if (wrap_pos) begin
						state_q <= S_WPOS;
					end else if (wrap_neg) begin
						state_q <= S_WNEG;
					end else begin
						state_q <= S_POS;
					end
				end
				// Forward wrap lands inside the last loop length.
				S_WPOS: begin
					if (div_done) begin
						phase_q <= last_fx - unit_fx + rem_ph;
						state_q <= S_POS;
					end
				end
				// Backward wrap lands at or above the loop start.
				S_WNEG: begin
					if (div_done) begin
						if (div_rem == '0) begin
							phase_q <= first_fx;
						end else begin
							phase_q <= first_fx + unit_fx - rem_ph;
						end
						state_q <= S_POS;
					end
				end
				S_F0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					if (act_q == slp_pkg::ACT_SET_START) begin
						if ((fv >= last_q) && (last_q != '0)) begin
							first_q <= last_q - AW'(1);
						end else begin
							first_q <= fv;
						end
					end else begin
						if (end_c > {1'b0, taken_q}) begin
							last_q <= taken_q;
						end else begin
							last_q <= end_c[AW-1:0];
						end
					end
					state_q <= S_POS;
				end
				S_POS: begin
					if (pos_ok) begin
						state_q <= S_PWAIT;
					end else begin
						pos_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_PWAIT: begin
					if (div_done) begin
						if (div_quo > ND'(slp_pkg::ONE_Q16)) begin
							pos_q <= slp_pkg::ONE_Q16;
						end else begin
							pos_q <= div_quo[slp_pkg::FRAC_W-1:0];
						end
						state_q <= S_OUT;
					end
				end
				// Hand the result to the output register once it is free.
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_l_q     <= lo_q;
						out_r_q     <= ro_q;
						out_pos_q   <= pos_q;
						out_play_q  <= play_q;
						out_rec_q   <= rec_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	slp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_left_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q[IW-1:0]),
		.wdata (in_ch.left_in),
		.raddr (raddr),
		.rdata (rd_l)
	);

	slp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_right_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (wp_q[IW-1:0]),
		.wdata (in_ch.right_in),
		.raddr (raddr),
		.rdata (rd_r)
	);

	slp_mul #(.AW(MA), .BW(MB)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	slp_div #(.W(ND)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.left_out     = out_l_q;
	assign out_ch.right_out    = out_r_q;
	assign out_ch.position     = out_pos_q;
	assign out_ch.is_playing   = out_play_q;
	assign out_ch.is_recording = out_rec_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == slp_pkg::REG_SPEED) ? slp_pkg::PDATA_W'(speed_q) : '0;
endmodule

// ===== sv/slp_checker.sv =====
// Port-level checker for the stereo looper, bound to the top level.
// Depends on slp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slp_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] left_out,
	input logic [slp_pkg::FRAC_W-1:0]    position
);
	// The sequencer stays busy after it accepts an item.
	`SLP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// The reported position never exceeds one full recording.
	`SLP_ASSERT_IMPL(a_position_range, clk, arst_n, out_valid, position <= slp_pkg::ONE_Q16)

	// A stalled result beat holds its contents.
	`SLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(left_out) && $stable(position))
endmodule

bind stereo_loop_sampler slp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_slp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.left_out  (out_ch.left_out),
	.position  (out_ch.position)
);
